@@ rtl/sliding_median_filter_assert.svh @@
// Assertion macros shared by the sliding median filter modules.
`ifndef SLIDING_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smf check failed");
`define SMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smf check failed");
`else
`define SMF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/smf_pkg.sv @@
// Shared constants and controller/datapath signal types of the median filter.
`timescale 1ns / 1ps
`default_nettype none
package smf_pkg;

    localparam int MAX_WINDOW_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int WIN_CFG_W  = 5;

    localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_SIZE  = 2'd0;
    localparam logic [WIN_CFG_W-1:0]  WINDOW_SIZE_RESET = 5'd3;

    typedef struct packed {
        logic load;
        logic scan;
        logic emit;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_median;
        logic scan_done;
        logic out_room;
        logic no_out;
        logic last_out;
    } t_dp_status;

endpackage
`default_nettype wire

@@ rtl/smf_in_if.sv @@
// Input stream channel: one sample and its end-of-signal flag per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface smf_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_signal;

    modport source (output valid, output sample, output end_of_signal, input ready);
    modport sink   (input valid, input sample, input end_of_signal, output ready);
endinterface
`default_nettype wire

@@ rtl/smf_out_if.sv @@
// Output stream channel: one filtered sample and its flags per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface smf_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          passed_raw;
    logic                          last_of_run;

    modport source (output valid, output filtered, output passed_raw, output last_of_run,
                    input ready);
    modport sink   (input valid, input filtered, input passed_raw, input last_of_run,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/smf_ctrl.sv @@
// Sequencer of the median filter: accept, rank scan, result emission.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_median_filter_assert.svh"
module smf_ctrl
    import smf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                if (i_status.no_out) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_status.need_median) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_room) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_out) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SMF_ASSERT_NEXT(a_load_to_prep, i_clk, i_rst_n, o_cmd.load, r_state == ST_PREP)
    `SMF_ASSERT_NOW(a_emit_has_room, i_clk, i_rst_n, o_cmd.emit, i_status.out_room)
    `SMF_ASSERT_NEXT(a_finish_to_idle, i_clk, i_rst_n, o_cmd.finish, r_state == ST_IDLE)

endmodule
`default_nettype wire

@@ rtl/smf_datapath.sv @@
// Datapath of the median filter: delay line, counts, rank scan, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_median_filter_assert.svh"
module smf_datapath
    import smf_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_ctrl_cmd                     i_cmd,
    output t_dp_status                         o_status,
    input  wire logic [WIN_CFG_W-1:0]          i_window_size,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_end_of_signal,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_filtered,
    output logic                               o_passed_raw,
    output logic                               o_last_of_run
);

    localparam int LINE_DEPTH = MAX_WINDOW + 1;
    localparam int SEEN_CAP   = MAX_WINDOW + 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SEEN_W     = $clog2(MAX_WINDOW + 2);
    localparam int RANK_W     = $clog2(LINE_DEPTH + 1);

    logic signed [SAMPLE_BITS-1:0] r_line [LINE_DEPTH];
    logic [SEEN_W-1:0]             r_seen;
    logic [CNT_W-1:0]              r_eb;
    logic                          r_last;
    logic [CNT_W-1:0]              r_pos;
    logic [CNT_W-1:0]              r_remain;
    logic [CNT_W-1:0]              r_scan_idx;
    logic                          r_cand_valid;
    logic signed [SAMPLE_BITS-1:0] r_cand;
    logic [CNT_W-1:0]              r_cand_pos;
    logic signed [SAMPLE_BITS-1:0] r_med_lo;
    logic signed [SAMPLE_BITS-1:0] r_med_hi;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filtered;
    logic                          r_passed_raw;
    logic                          r_last_of_run;

    logic [CNT_W-1:0]              w;
    logic [CNT_W-1:0]              h;
    logic                          odd;
    logic [CNT_W-1:0]              first;
    logic [CNT_W:0]                win_end;
    logic                          seen_ok;
    logic [SEEN_W-1:0]             seen_inc;
    logic [CNT_W-1:0]              eb_inc;
    logic [CNT_W-1:0]              stop;
    logic [CNT_W-1:0]              rd_idx;
    logic signed [SAMPLE_BITS-1:0] rd_val;
    logic [LINE_DEPTH-1:0]         less;
    logic [RANK_W-1:0]             rank;
    logic [RANK_W-1:0]             hi_rank;
    logic [RANK_W-1:0]             lo_rank;
    logic signed [SAMPLE_BITS:0]   sum;
    logic signed [SAMPLE_BITS:0]   sum_sh;
    logic signed [SAMPLE_BITS-1:0] median;
    logic                          filt;

    always_comb begin
        if (i_window_size == '0) begin
            w = CNT_W'(1);
        end else if (int'(i_window_size) > MAX_WINDOW) begin
            w = CNT_W'(MAX_WINDOW);
        end else begin
            w = CNT_W'(i_window_size);
        end
    end

    assign h        = w >> 1;
    assign odd      = w[0];
    assign first    = odd ? '0 : CNT_W'(1);
    assign win_end  = {1'b0, w} + (CNT_W + 1)'(first);
    assign seen_ok  = (CNT_W + 1)'(r_seen) >= {h, 1'b1};
    assign seen_inc = (r_seen < SEEN_W'(SEEN_CAP)) ? r_seen + SEEN_W'(1) : r_seen;
    assign eb_inc   = (r_eb < CNT_W'(MAX_WINDOW)) ? r_eb + CNT_W'(1) : r_eb;
    assign stop     = i_end_of_signal ? '0 : h;

    assign rd_idx = i_cmd.scan ? first + r_scan_idx : r_pos;
    assign rd_val = (int'(rd_idx) < LINE_DEPTH) ? r_line[rd_idx] : '0;

    always_comb begin
        for (int p = 0; p < LINE_DEPTH; p++) begin
            less[p] = ((CNT_W + 1)'(p) >= (CNT_W + 1)'(first))
                   && ((CNT_W + 1)'(p) < win_end)
                   && ((r_line[p] < r_cand)
                       || ((r_line[p] == r_cand) && (CNT_W'(p) < r_cand_pos)));
        end
    end

    assign rank    = RANK_W'($countones(less));
    assign hi_rank = RANK_W'(h);
    assign lo_rank = RANK_W'(h) - RANK_W'(1);

    assign sum    = $signed({r_med_lo[SAMPLE_BITS-1], r_med_lo})
                  + $signed({r_med_hi[SAMPLE_BITS-1], r_med_hi});
    assign sum_sh = sum >>> 1;
    assign median = odd ? r_med_hi : sum_sh[SAMPLE_BITS-1:0];
    assign filt   = (r_pos == h) && seen_ok;

    assign o_status.need_median = seen_ok;
    assign o_status.scan_done   = (r_scan_idx == w) && !r_cand_valid;
    assign o_status.out_room    = !r_out_valid || i_out_ready;
    assign o_status.no_out      = (r_remain == '0);
    assign o_status.last_out    = (r_remain == CNT_W'(1));

    // delay line, newest at position 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_line[0] <= i_sample;
            for (int p = 1; p < LINE_DEPTH; p++) begin
                r_line[p] <= r_line[p-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= '0;
            r_eb         <= '0;
            r_last       <= 1'b0;
            r_pos        <= '0;
            r_remain     <= '0;
            r_scan_idx   <= '0;
            r_cand_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_seen       <= seen_inc;
                r_eb         <= eb_inc;
                r_last       <= i_end_of_signal;
                r_pos        <= eb_inc - CNT_W'(1);
                r_remain     <= (eb_inc > stop) ? eb_inc - stop : '0;
                r_scan_idx   <= '0;
                r_cand_valid <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    if (r_scan_idx < w) begin
                        r_scan_idx   <= r_scan_idx + CNT_W'(1);
                        r_cand_valid <= 1'b1;
                    end else begin
                        r_cand_valid <= 1'b0;
                    end
                end
                if (i_cmd.emit) begin
                    r_pos    <= r_pos - CNT_W'(1);
                    r_remain <= r_remain - CNT_W'(1);
                end
                if (i_cmd.finish) begin
                    if (r_last) begin
                        r_seen <= '0;
                        r_eb   <= '0;
                    end else if (r_eb > h) begin
                        r_eb <= h;
                    end
                end
            end
        end
    end

    // rank scan: load a candidate, then count the window entries that sort below it
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && (r_scan_idx < w)) begin
            r_cand     <= rd_val;
            r_cand_pos <= rd_idx;
        end
        if (r_cand_valid) begin
            if (rank == hi_rank) begin
                r_med_hi <= r_cand;
            end
            if (!odd && (rank == lo_rank)) begin
                r_med_lo <= r_cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_filtered    <= filt ? median : rd_val;
            r_passed_raw  <= !filt;
            r_last_of_run <= (r_remain == CNT_W'(1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_filtered    = r_filtered;
    assign o_passed_raw  = r_passed_raw;
    assign o_last_of_run = r_last_of_run;

    `SMF_ASSERT_NOW(a_emit_pending, i_clk, i_rst_n, i_cmd.emit, r_remain != '0)
    `SMF_ASSERT_NOW(a_cand_after_issue, i_clk, i_rst_n, r_cand_valid, r_scan_idx != '0)
    `SMF_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_cmd.finish && r_last, (r_seen == '0) && (r_eb == '0))

endmodule
`default_nettype wire

@@ rtl/sliding_median_filter.sv @@
// Top level of the sliding median filter: register port, sequencer and datapath.
//
//  channel   direction  transfer when            payload
//  i_in      in         i_in.valid & ready       sample, end_of_signal
//  o_out     out        o_out.valid & ready      filtered, passed_raw, last_of_run
//  apb       in         psel & penable & pwrite  window_size at byte address 0
//
// One item at a time: an item is loaded, then rank-scanned when its window is full
// enough for a median, then its results are emitted one by one; the rank scan tests
// one window entry per cycle against all others.
// Synchronous active-low reset clears the counts and the sequencer and sets the window size to 3.
// A stalled output holds its register; emission waits, input stays closed until done.
`timescale 1ns / 1ps
`default_nettype none
module sliding_median_filter
    import smf_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready,
    smf_in_if.sink                     i_in,
    smf_out_if.source                  o_out
);

    logic [WIN_CFG_W-1:0] r_window_size;
    t_ctrl_cmd            cmd;
    t_dp_status           status;
    logic                 in_ready;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW_SIZE) ? CFG_DATA_W'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_SIZE)) begin
            r_window_size <= pwdata[WIN_CFG_W-1:0];
        end
    end

    assign i_in.ready = in_ready;

    smf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    smf_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_window_size   (r_window_size),
        .i_sample        (i_in.sample),
        .i_end_of_signal (i_in.end_of_signal),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_filtered      (o_out.filtered),
        .o_passed_raw    (o_out.passed_raw),
        .o_last_of_run   (o_out.last_of_run)
    );

endmodule
`default_nettype wire
